// ===== sv/ilist_pkg.sv =====
// ilist_pkg: shared types and codes for the indexed list engine
// action and status codes, word type, cell control struct
// no dependencies
`default_nettype none

package ilist_pkg;

	typedef logic signed [31:0] data_t;
	typedef logic [3:0]         action_t;
	typedef logic [1:0]         status_t;

	localparam action_t ACT_PUSH_END   = 4'd0;
	localparam action_t ACT_PUSH_FRONT = 4'd1;
	localparam action_t ACT_INSERT     = 4'd2;
	localparam action_t ACT_READ       = 4'd3;
	localparam action_t ACT_REMOVE     = 4'd4;
	localparam action_t ACT_POP_FRONT  = 4'd5;
	localparam action_t ACT_POP_END    = 4'd6;
	localparam action_t ACT_FIND_FIRST = 4'd7;
	localparam action_t ACT_FIND_LAST  = 4'd8;
	localparam action_t ACT_MAX_INDEX  = 4'd9;
	localparam action_t ACT_CLEAR      = 4'd10;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_FULL  = 2'd2;
	localparam status_t ST_EMPTY = 2'd3;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_ROTATE,
		CM_INSERT,
		CM_DELETE
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		data_t      value;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/ilist_if.sv =====
// ilist_if: valid/ready channel interfaces for request and response words
// depends on ilist_pkg
`default_nettype none

interface ilist_in_if #(parameter int CW = 7);
	import ilist_pkg::*;

	logic          valid;
	logic          ready;
	action_t       action;
	data_t         item_value;
	logic [CW-1:0] position;

	modport source(output valid, action, item_value, position, input ready);
	modport sink(input valid, action, item_value, position, output ready);
endinterface

interface ilist_out_if #(parameter int CW = 7, parameter int IW = 6);
	import ilist_pkg::*;

	logic          valid;
	logic          ready;
	status_t       status;
	logic          found;
	data_t         result_value;
	logic [IW-1:0] result_index;
	logic [CW-1:0] item_count;

	modport source(output valid, status, found, result_value, result_index, item_count,
		input ready);
	modport sink(input valid, status, found, result_value, result_index, item_count,
		output ready);
endinterface

`default_nettype wire

// ===== sv/indexed_list_engine.sv =====
// indexed_list_engine: packed list of signed 32-bit words held in a ring of cells.
// Inserts shift the cells above the position up as the request is taken. Reads, removes,
// searches and the max scan rotate the whole ring once past a compare unit at
// cell 0 in the scan state; a remove then closes the gap in the shift state.
// Inserts, clear and refused actions go straight to the result state; reads,
// searches and max go through scan, removes through scan and shift. A new request
// word is taken once the previous one has reached the output register, which
// holds its result until the response side takes it.
// depends on ilist_pkg, ilist_if, ilist_cell, ilist_scan
`default_nettype none

module indexed_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	ilist_in_if.sink    request,
	ilist_out_if.source response
);
	import ilist_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
	localparam logic [IW-1:0] LAST_K     = IW'(CAPACITY - 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_SHIFT  = 2'd2;
	localparam logic [1:0] S_RESULT = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] k_q;
	logic          out_valid_q;

	action_t       action_q;
	data_t         key_q;
	logic [IW-1:0] tgt_q;
	status_t       status_q;

	status_t       out_status_q;
	logic          out_found_q;
	data_t         out_value_q;
	logic [IW-1:0] out_index_q;
	logic [CW-1:0] out_count_q;

	logic          in_fire;
	logic          out_load;
	logic          del_op;
	logic [CW-1:0] req_pos;
	status_t       req_status;
	logic          ins_ok;
	logic          scan_req;
	logic [CW-1:0] ins_pos;
	logic [IW-1:0] req_tgt;

	cell_ctl_t     ctl;
	logic [CW-1:0] cell_pos;
	data_t         cell_data [CAPACITY];

	logic          scan_found;
	data_t         scan_rval;
	logic [IW-1:0] scan_ridx;

	assign request.ready = state_q == S_IDLE;
	assign in_fire       = request.valid && request.ready;
	assign out_load      = state_q == S_RESULT && (!out_valid_q || response.ready);
	assign req_pos       = CW'(request.position);
	assign del_op        = action_q == ACT_REMOVE || action_q == ACT_POP_FRONT
		|| action_q == ACT_POP_END;

	// admission checks against the current count
	always_comb begin
		req_status = ST_OK;
		ins_ok     = 1'b0;
		scan_req   = 1'b0;
		ins_pos    = '0;
		req_tgt    = '0;
		unique case (request.action)
			ACT_PUSH_END, ACT_PUSH_FRONT: begin
				if (count_q == FULL_COUNT) begin
					req_status = ST_FULL;
				end else begin
					ins_ok  = 1'b1;
					ins_pos = (request.action == ACT_PUSH_END) ? count_q : '0;
				end
			end
			ACT_INSERT: begin
				if (req_pos > count_q) begin
					req_status = ST_RANGE;
				end else if (count_q == FULL_COUNT) begin
					req_status = ST_FULL;
				end else begin
					ins_ok  = 1'b1;
					ins_pos = req_pos;
				end
			end
			ACT_READ, ACT_REMOVE: begin
				if (count_q == '0) begin
					req_status = ST_EMPTY;
				end else if (req_pos >= count_q) begin
					req_status = ST_RANGE;
				end else begin
					scan_req = 1'b1;
					req_tgt  = IW'(req_pos);
				end
			end
			ACT_POP_FRONT: begin
				if (count_q == '0) begin
					req_status = ST_EMPTY;
				end else begin
					scan_req = 1'b1;
				end
			end
			ACT_POP_END: begin
				if (count_q == '0) begin
					req_status = ST_EMPTY;
				end else begin
					scan_req = 1'b1;
					req_tgt  = IW'(count_q - CW'(1));
				end
			end
			ACT_FIND_FIRST, ACT_FIND_LAST: begin
				scan_req = 1'b1;
			end
			ACT_MAX_INDEX: begin
				if (count_q == '0) begin
					req_status = ST_EMPTY;
				end else begin
					scan_req = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// cell ring command
	always_comb begin
		ctl.value = request.item_value;
		ctl.mode  = CM_HOLD;
		cell_pos  = ins_pos;
		priority if (in_fire && ins_ok) begin
			ctl.mode = CM_INSERT;
		end else if (state_q == S_SCAN) begin
			ctl.mode = CM_ROTATE;
		end else if (state_q == S_SHIFT) begin
			ctl.mode = CM_DELETE;
			cell_pos = CW'(tgt_q);
		end else begin
			ctl.mode = CM_HOLD;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ilist_cell #(
			.CW  (CW),
			.IDX (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.pos   (cell_pos),
			.lower (cell_data[(i + CAPACITY - 1) % CAPACITY]),
			.upper (cell_data[(i + 1) % CAPACITY]),
			.data  (cell_data[i])
		);
	end

	ilist_scan #(
		.CW (CW),
		.IW (IW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.step   (state_q == S_SCAN),
		.action (action_q),
		.key    (key_q),
		.tgt    (tgt_q),
		.k      (k_q),
		.count  (count_q),
		.head   (cell_data[0]),
		.found  (scan_found),
		.rval   (scan_rval),
		.ridx   (scan_ridx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (response.valid && response.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						k_q     <= '0;
						state_q <= scan_req ? S_SCAN : S_RESULT;
						if (ins_ok) begin
							count_q <= count_q + CW'(1);
						end else if (request.action == ACT_CLEAR) begin
							count_q <= '0;
						end
					end
				end
				S_SCAN: begin
					k_q <= k_q + IW'(1);
					if (k_q == LAST_K) begin
						state_q <= del_op ? S_SHIFT : S_RESULT;
					end
				end
				S_SHIFT: begin
					count_q <= count_q - CW'(1);
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_q <= request.action;
			key_q    <= request.item_value;
			tgt_q    <= req_tgt;
			status_q <= req_status;
		end
		if (out_load) begin
			out_status_q <= status_q;
			out_found_q  <= scan_found;
			out_value_q  <= scan_rval;
			out_index_q  <= scan_ridx;
			out_count_q  <= count_q;
		end
	end

	assign response.valid        = out_valid_q;
	assign response.status       = out_status_q;
	assign response.found        = out_found_q;
	assign response.result_value = out_value_q;
	assign response.result_index = out_index_q;
	assign response.item_count   = out_count_q;

endmodule

`default_nettype wire

// ===== sv/ilist_cell.sv =====
// ilist_cell: one storage cell of the list ring
// holds one entry, shifts to or from its neighbors on command
// depends on ilist_pkg
`default_nettype none

module ilist_cell #(
	parameter int CW  = 7,
	parameter int IDX = 0
) (
	input  logic                clk,
	input  ilist_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]       pos,
	input  ilist_pkg::data_t    lower,
	input  ilist_pkg::data_t    upper,
	output ilist_pkg::data_t    data
);
	import ilist_pkg::*;

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	data_t data_q;

	always_ff @(posedge clk) begin
		unique case (ctl.mode)
			CM_HOLD: begin
				data_q <= data_q;
			end
			CM_ROTATE: begin
				data_q <= upper;
			end
			CM_INSERT: begin
				if (MY_IDX > pos) begin
					data_q <= lower;
				end else if (MY_IDX == pos) begin
					data_q <= ctl.value;
				end
			end
			CM_DELETE: begin
				if (MY_IDX >= pos) begin
					data_q <= upper;
				end
			end
		endcase
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== sv/ilist_scan.sv =====
// ilist_scan: compare unit at the head of the ring
// sees one entry per cycle during a rotation and gathers read, search and max results
// depends on ilist_pkg
`default_nettype none

module ilist_scan #(
	parameter int CW = 7,
	parameter int IW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              step,
	input  ilist_pkg::action_t action,
	input  ilist_pkg::data_t  key,
	input  logic [IW-1:0]     tgt,
	input  logic [IW-1:0]     k,
	input  logic [CW-1:0]     count,
	input  ilist_pkg::data_t  head,
	output logic              found,
	output ilist_pkg::data_t  rval,
	output logic [IW-1:0]     ridx
);
	import ilist_pkg::*;

	logic          found_q;
	data_t         rval_q;
	logic [IW-1:0] ridx_q;
	data_t         best_q;
	logic          in_range;

	assign in_range = CW'(k) < count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			rval_q  <= '0;
			ridx_q  <= '0;
			best_q  <= '0;
		end else if (start) begin
			found_q <= 1'b0;
			rval_q  <= '0;
			ridx_q  <= '0;
		end else if (step) begin
			unique case (action)
				ACT_READ, ACT_REMOVE, ACT_POP_FRONT, ACT_POP_END: begin
					if (k == tgt) begin
						rval_q <= head;
					end
				end
				ACT_FIND_FIRST: begin
					if (in_range && head == key && !found_q) begin
						found_q <= 1'b1;
						ridx_q  <= k;
					end
				end
				ACT_FIND_LAST: begin
					if (in_range && head == key) begin
						found_q <= 1'b1;
						ridx_q  <= k;
					end
				end
				ACT_MAX_INDEX: begin
					if (k == '0) begin
						best_q <= head;
					end else if (in_range && head > best_q) begin
						best_q <= head;
						ridx_q <= k;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign found = found_q;
	assign rval  = rval_q;
	assign ridx  = ridx_q;

endmodule

`default_nettype wire

// ===== verif/ilist_checker.sv =====
`timescale 1ns / 100ps
// ilist_checker: watches the request and response channels of the indexed list engine,
// predicts each response word from its own copy of the list and compares field by field
// depends on ilist_pkg
module ilist_checker #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  ilist_pkg::action_t req_action,
	input  ilist_pkg::data_t   req_value,
	input  logic [6:0]         req_position,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  ilist_pkg::status_t rsp_status,
	input  logic               rsp_found,
	input  ilist_pkg::data_t   rsp_value,
	input  logic [5:0]         rsp_index,
	input  logic [6:0]         rsp_count,
	output int                 errors,
	output int                 waiting
);
	import ilist_pkg::*;

	typedef struct packed {
		status_t    status;
		logic       found;
		data_t      value;
		logic [5:0] index;
		logic [6:0] count;
	} outcome_t;

	data_t    list_words [CAPACITY];
	int       list_len;
	outcome_t outcome_q [$];
	outcome_t got_word;
	outcome_t want_word;

	function automatic void open_gap(int at, data_t v);
		int i;
		for (i = list_len; i > at; i--)
			list_words[i] = list_words[i - 1];
		list_words[at] = v;
		list_len++;
	endfunction

	function automatic data_t close_gap(int at);
		data_t v;
		int    i;
		v = list_words[at];
		for (i = at; i + 1 < list_len; i++)
			list_words[i] = list_words[i + 1];
		list_len--;
		return v;
	endfunction

	function automatic outcome_t apply_action(action_t a, data_t v, logic [6:0] p);
		outcome_t o;
		data_t    best;
		int       i;
		o = '0;
		case (a)
			ACT_PUSH_END, ACT_PUSH_FRONT: begin
				if (list_len >= CAPACITY)
					o.status = ST_FULL;
				else
					open_gap((a == ACT_PUSH_END) ? list_len : 0, v);
			end
			ACT_INSERT: begin
				if (int'(p) > list_len)
					o.status = ST_RANGE;
				else if (list_len >= CAPACITY)
					o.status = ST_FULL;
				else
					open_gap(int'(p), v);
			end
			ACT_READ, ACT_REMOVE: begin
				if (list_len == 0)
					o.status = ST_EMPTY;
				else if (int'(p) >= list_len)
					o.status = ST_RANGE;
				else if (a == ACT_READ)
					o.value = list_words[p];
				else
					o.value = close_gap(int'(p));
			end
			ACT_POP_FRONT, ACT_POP_END: begin
				if (list_len == 0)
					o.status = ST_EMPTY;
				else
					o.value = close_gap((a == ACT_POP_FRONT) ? 0 : list_len - 1);
			end
			ACT_FIND_FIRST: begin
				for (i = 0; i < list_len; i++)
					if (!o.found && list_words[i] == v) begin
						o.found = 1'b1;
						o.index = 6'(i);
					end
			end
			ACT_FIND_LAST: begin
				for (i = 0; i < list_len; i++)
					if (list_words[i] == v) begin
						o.found = 1'b1;
						o.index = 6'(i);
					end
			end
			ACT_MAX_INDEX: begin
				if (list_len == 0) begin
					o.status = ST_EMPTY;
				end else begin
					best = list_words[0];
					for (i = 1; i < list_len; i++)
						if (list_words[i] > best) begin
							best = list_words[i];
							o.index = 6'(i);
						end
				end
			end
			ACT_CLEAR: begin
				for (i = 0; i < CAPACITY; i++)
					list_words[i] = '0;
				list_len = 0;
			end
			default: ;
		endcase
		o.count = 7'(list_len);
		return o;
	endfunction

	task automatic report_word(bit expected, outcome_t want, outcome_t got);
		errors++;
		if (errors <= 10) begin
			if (expected)
				$display("%0t mismatch: want st=%0d found=%0b val=%0d idx=%0d cnt=%0d",
					$realtime, want.status, want.found, want.value, want.index, want.count);
			else
				$display("%0t response word with no request outstanding", $realtime);
			$display("%0t          got  st=%0d found=%0b val=%0d idx=%0d cnt=%0d",
				$realtime, got.status, got.found, got.value, got.index, got.count);
		end
	endtask

	initial begin
		errors   = 0;
		waiting  = 0;
		list_len = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outcome_q.delete();
			list_len = 0;
			waiting  = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				got_word = '{rsp_status, rsp_found, rsp_value, rsp_index, rsp_count};
				if (outcome_q.size() == 0) begin
					report_word(1'b0, '0, got_word);
				end else begin
					want_word = outcome_q.pop_front();
					if (got_word !== want_word)
						report_word(1'b1, want_word, got_word);
				end
			end
			if (req_valid && req_ready)
				outcome_q.push_back(apply_action(req_action, req_value, req_position));
			waiting = outcome_q.size();
		end
	end

endmodule

// ===== verif/indexed_list_engine_tb.sv =====
`timescale 1ns / 100ps
// indexed_list_engine_tb: drives directed and random list operations into the engine
// with random sender gaps and receiver stalls; the verdict comes from ilist_checker
// depends on ilist_pkg, ilist_if, indexed_list_engine, ilist_checker
module indexed_list_engine_tb;
	import ilist_pkg::*;

	localparam int      CAPACITY         = 64;
	localparam int      SEGMENT_WORDS    = 80;
	localparam int      RANDOM_WORDS     = 1700;
	localparam action_t ACT_FIRST_UNUSED = 4'd11;
	localparam action_t ACT_LAST_UNUSED  = 4'd15;

	logic clk = 1'b0;
	logic arst_n;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned shadow_len;
	int          errors;
	int          waiting;

	data_t value_pool [8] = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000,
		32'sd100, -32'sd100, 32'sd5};

	ilist_in_if  #(.CW(7))          req_ch ();
	ilist_out_if #(.CW(7), .IW(6))  rsp_ch ();

	indexed_list_engine #(.CAPACITY(CAPACITY)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_ch),
		.response (rsp_ch)
	);

	ilist_checker #(.CAPACITY(CAPACITY)) list_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_ch.valid),
		.req_ready    (req_ch.ready),
		.req_action   (req_ch.action),
		.req_value    (req_ch.item_value),
		.req_position (req_ch.position),
		.rsp_valid    (rsp_ch.valid),
		.rsp_ready    (rsp_ch.ready),
		.rsp_status   (rsp_ch.status),
		.rsp_found    (rsp_ch.found),
		.rsp_value    (rsp_ch.result_value),
		.rsp_index    (rsp_ch.result_index),
		.rsp_count    (rsp_ch.item_count),
		.errors       (errors),
		.waiting      (waiting)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial rsp_ch.ready = 1'b0;

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic put_word(action_t a, data_t v, logic [6:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.action     <= a;
		req_ch.item_value <= v;
		req_ch.position   <= p;
		do @(posedge clk); while (!req_ch.ready);
		case (a)
			ACT_PUSH_END, ACT_PUSH_FRONT: if (shadow_len < CAPACITY) shadow_len++;
			ACT_INSERT: if (p <= shadow_len && shadow_len < CAPACITY) shadow_len++;
			ACT_REMOVE: if (shadow_len != 0 && p < shadow_len) shadow_len--;
			ACT_POP_FRONT, ACT_POP_END: if (shadow_len != 0) shadow_len--;
			ACT_CLEAR: shadow_len = 0;
			default: ;
		endcase
	endtask

	function automatic data_t pick_value();
		case ($urandom_range(9))
			0, 1, 2, 3: return value_pool[$urandom_range(7)];
			4:          return data_t'(int'($urandom_range(15)) - 8);
			default:    return data_t'($urandom);
		endcase
	endfunction

	function automatic logic [6:0] pick_position(int unsigned span);
		if (span == 0 || $urandom_range(9) == 0)
			return 7'($urandom_range(127));
		return 7'($urandom_range(span - 1));
	endfunction

	function automatic data_t pick_key();
		if ($urandom_range(9) < 7)
			return value_pool[$urandom_range(7)];
		return pick_value();
	endfunction

	initial begin
		int seg;
		int done;
		int r;
		int ins_w;
		int rem_w;

		arst_n            = 1'b0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		shadow_len        = 0;
		req_ch.valid      = 1'b0;
		req_ch.action     = ACT_PUSH_END;
		req_ch.item_value = '0;
		req_ch.position   = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list and range corners
		put_word(ACT_READ, 32'sd0, 7'd0);
		put_word(ACT_REMOVE, 32'sd0, 7'd0);
		put_word(ACT_POP_FRONT, 32'sd0, 7'd0);
		put_word(ACT_POP_END, 32'sd0, 7'd0);
		put_word(ACT_MAX_INDEX, 32'sd0, 7'd0);
		put_word(ACT_FIND_FIRST, 32'sd0, 7'd0);
		put_word(ACT_INSERT, 32'sd7, 7'd1);
		put_word(ACT_FIND_LAST, 32'sd0, 7'd0);
		// fill with extremes
		put_word(ACT_PUSH_END, 32'sh7fffffff, 7'd127);
		put_word(ACT_PUSH_FRONT, 32'sh80000000, 7'd0);
		put_word(ACT_INSERT, -32'sd1, 7'd1);
		put_word(ACT_INSERT, 32'sd0, 7'd3);
		put_word(ACT_INSERT, 32'sd9, 7'd5);
		put_word(ACT_PUSH_END, -32'sd1, 7'd0);
		put_word(ACT_READ, 32'sd0, 7'd3);
		put_word(ACT_READ, 32'sd0, 7'd5);
		put_word(ACT_READ, 32'sd0, 7'd127);
		put_word(ACT_FIND_FIRST, -32'sd1, 7'd0);
		put_word(ACT_FIND_LAST, -32'sd1, 7'd0);
		// max tie between the front and an inner entry of the list
		put_word(ACT_PUSH_FRONT, 32'sh7fffffff, 7'd0);
		put_word(ACT_MAX_INDEX, 32'sd0, 7'd0);
		put_word(ACT_REMOVE, 32'sd0, 7'd2);
		put_word(ACT_POP_FRONT, 32'sd0, 7'd0);
		put_word(ACT_POP_END, 32'sd0, 7'd0);
		put_word(ACT_LAST_UNUSED, 32'sh7fffffff, 7'd127);
		put_word(ACT_CLEAR, 32'sd0, 7'd0);

		done = 0;
		seg  = 0;
		while (done < RANDOM_WORDS) begin
			case (seg % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			case (seg % 6)
				0, 1: begin ins_w = 65; rem_w = 15; end
				3, 4: begin ins_w = 15; rem_w = 65; end
				default: begin ins_w = 40; rem_w = 35; end
			endcase
			repeat (SEGMENT_WORDS) begin
				r = $urandom_range(99);
				if (r < ins_w) begin
					case ($urandom_range(2))
						0: put_word(ACT_PUSH_END, pick_value(), 7'($urandom_range(127)));
						1: put_word(ACT_PUSH_FRONT, pick_value(), 7'($urandom_range(127)));
						default: put_word(ACT_INSERT, pick_value(), pick_position(shadow_len + 1));
					endcase
					done++;
				end else if (r < ins_w + rem_w) begin
					case ($urandom_range(2))
						0: put_word(ACT_REMOVE, data_t'($urandom), pick_position(shadow_len));
						1: put_word(ACT_POP_FRONT, data_t'($urandom), 7'($urandom_range(127)));
						default: put_word(ACT_POP_END, data_t'($urandom), 7'($urandom_range(127)));
					endcase
					done++;
				end else if (r < 97) begin
					case ($urandom_range(3))
						0: put_word(ACT_READ, data_t'($urandom), pick_position(shadow_len));
						1: put_word(ACT_FIND_FIRST, pick_key(), 7'($urandom_range(127)));
						2: put_word(ACT_FIND_LAST, pick_key(), 7'($urandom_range(127)));
						default: put_word(ACT_MAX_INDEX, data_t'($urandom), 7'($urandom_range(127)));
					endcase
					done++;
				end else if (r < 99) begin
					put_word(action_t'(ACT_FIRST_UNUSED + $urandom_range(4)), data_t'($urandom),
						7'($urandom_range(127)));
				end else begin
					put_word(ACT_CLEAR, data_t'($urandom), 7'($urandom_range(127)));
					done++;
				end
			end
			seg++;
		end
		req_ch.valid <= 1'b0;

		wait (waiting == 0);
		repeat (CAPACITY + 8) @(posedge clk);
		if (errors == 0 && waiting == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
